// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the sorted table RTL.
// Each macro expects clk and rst to be visible in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/sti_pkg.sv -----
// Types and codes for the sorted table block.
// Used by sti_ctrl, sti_datapath and sorted_table_insert_delete.
package sti_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 6;

  typedef enum logic [1:0] {
    FN_APPEND = 2'd0,
    FN_INSERT = 2'd1,
    FN_DELETE = 2'd2,
    FN_READ   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOTFOUND = 3'd1,
    ST_FULL     = 3'd2,
    ST_ENTRY    = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_APPEND,
    OP_SORT_START,
    OP_SORT_FIRST,
    OP_SORT_STEP,
    OP_SORT_TAIL,
    OP_DEL_START,
    OP_DEL_STEP,
    OP_DEL_DONE,
    OP_RD_ISSUE,
    OP_RD_NEXT
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    logic    out_load;
    status_t out_status;
    logic    use_entry;
    logic    use_removed;
    logic    out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic insert;
    logic swapped;
    logic run_last;
    logic del_last;
    logic del_none;
    logic rd_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- rtl/core/sorted_table_insert_delete.sv -----
// Top level of the sorted table: a table of up to DEPTH signed 32-bit entries.
// Depends on sti_pkg, sti_ctrl and sti_datapath.
//
// Input channel (item_valid/item_stall, func, value): one transaction per
// operation: append, insert then sort ascending, delete all equal, read out.
// Output channel (result_valid/result_stall, status, entry, entry_count,
// removed, last): one transaction per operation, or one per entry on a
// read-out; last marks the final one.
// Steps per operation, from acceptance to the result in the output register:
//   append: load, write, result; full, empty or not-found answer on an empty table: load, result
//   insert: as append, then up to fill passes (bubble passes over
//           the entry memory, ending after a pass without a swap)
//   delete: one compaction pass, one read a cycle and one write per kept entry
//   read-out: per entry, a read from the entry memory, then a load of the output register
// A new operation is accepted only when the previous one is finished; the
// output register lets it be accepted while the last result is still held.
// A stalled receiver holds the result and pauses a read-out or the final
// answer. Reset empties the table (count to zero); entry storage is not cleared.
module sorted_table_insert_delete #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic [1:0]                        func,
  input  logic signed [sti_pkg::DATA_W-1:0] value,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [2:0]                        status,
  output logic signed [sti_pkg::DATA_W-1:0] entry,
  output logic [sti_pkg::COUNT_W-1:0]       entry_count,
  output logic [sti_pkg::COUNT_W-1:0]       removed,
  output logic                              last
);
  import sti_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sti_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .func       (func),
    .item_stall (item_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  sti_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .func         (func),
    .value        (value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .entry        (entry),
    .entry_count  (entry_count),
    .removed      (removed),
    .last         (last)
  );

endmodule

// ----- rtl/core/sti_datapath.sv -----
// Datapath of the sorted table: entry memory, counters, sort carry and result register.
// Depends on sti_pkg and assert_macros.svh; driven by sti_ctrl.
`include "assert_macros.svh"

module sti_datapath #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  sti_pkg::dp_cmd_t                  cmd,
  output sti_pkg::dp_stat_t                 stat,
  input  logic [1:0]                        func,
  input  logic signed [sti_pkg::DATA_W-1:0] value,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [2:0]                        status,
  output logic signed [sti_pkg::DATA_W-1:0] entry,
  output logic [sti_pkg::COUNT_W-1:0]       entry_count,
  output logic [sti_pkg::COUNT_W-1:0]       removed,
  output logic                              last
);
  import sti_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rd_data;
  logic signed [DATA_W-1:0] val_r;
  logic signed [DATA_W-1:0] carry;
  logic [1:0]               func_r;
  logic [CW-1:0]            fill;
  logic [CW-1:0]            idx;
  logic [CW-1:0]            wptr;
  logic [CW-1:0]            removed_r;
  logic                     swapped;

  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic signed [DATA_W-1:0] wr_data;
  logic                     ahead;
  logic                     greater;
  logic                     keep;

  assign ahead   = idx < fill;
  assign greater = carry > rd_data;
  assign keep    = rd_data != val_r;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = AW'(idx);
    wr_en   = 1'b0;
    wr_addr = AW'(wptr);
    wr_data = rd_data;
    unique case (cmd.op)
      OP_APPEND: begin
        wr_en   = 1'b1;
        wr_addr = AW'(fill);
        wr_data = val_r;
      end
      OP_SORT_START, OP_DEL_START: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      OP_SORT_FIRST, OP_RD_ISSUE: begin
        rd_en = 1'b1;
      end
      OP_SORT_STEP: begin
        rd_en   = ahead;
        wr_en   = 1'b1;
        wr_data = greater ? rd_data : carry;
      end
      OP_SORT_TAIL: begin
        wr_en   = 1'b1;
        wr_addr = AW'(fill - CW'(1));
        wr_data = carry;
      end
      OP_DEL_STEP: begin
        rd_en = ahead;
        wr_en = keep;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      unique case (cmd.op)
        OP_APPEND:   fill <= fill + CW'(1);
        OP_DEL_DONE: fill <= wptr;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        func_r    <= func;
        val_r     <= value;
        idx       <= '0;
        removed_r <= '0;
      end
      OP_SORT_START: begin
        idx     <= CW'(1);
        wptr    <= '0;
        swapped <= 1'b0;
      end
      OP_SORT_FIRST: begin
        carry <= rd_data;
        idx   <= idx + CW'(1);
      end
      OP_SORT_STEP: begin
        idx  <= idx + CW'(1);
        wptr <= wptr + CW'(1);
        if (greater) begin
          swapped <= 1'b1;
        end else begin
          carry <= rd_data;
        end
      end
      OP_DEL_START: begin
        idx  <= CW'(1);
        wptr <= '0;
      end
      OP_DEL_STEP: begin
        idx <= idx + CW'(1);
        if (keep) begin
          wptr <= wptr + CW'(1);
        end
      end
      OP_DEL_DONE: begin
        removed_r <= fill - wptr;
      end
      OP_RD_NEXT: begin
        idx <= idx + CW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status      <= cmd.out_status;
      entry       <= cmd.use_entry ? rd_data : '0;
      entry_count <= COUNT_W'(fill);
      removed     <= cmd.use_removed ? COUNT_W'(removed_r) : '0;
      last        <= cmd.out_last;
    end
  end

  always_comb begin
    stat.full     = fill == CW'(DEPTH);
    stat.empty    = fill == '0;
    stat.insert   = func_r == FN_INSERT;
    stat.swapped  = swapped;
    stat.run_last = CW'(wptr + CW'(2)) == fill;
    stat.del_last = idx == fill;
    stat.del_none = wptr == fill;
    stat.rd_last  = CW'(idx + CW'(1)) == fill;
    stat.out_free = !result_valid || !result_stall;
  end

  `ASSERT_IMPL(a_append_room, cmd.op == OP_APPEND, fill < CW'(DEPTH), "append into full table")
  `ASSERT_NEXT(a_delete_shrinks, cmd.op == OP_DEL_DONE, fill <= $past(fill), "delete grew table")

endmodule

// ----- rtl/core/sti_ctrl.sv -----
// Controller of the sorted table: sequences append, sort passes, delete and read-out.
// Depends on sti_pkg and assert_macros.svh; commands sti_datapath.
`include "assert_macros.svh"

module sti_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic [1:0]        func,
  output logic              item_stall,
  input  sti_pkg::dp_stat_t stat,
  output sti_pkg::dp_cmd_t  cmd
);
  import sti_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE       = 13'b0000000000001,
    S_APPEND     = 13'b0000000000010,
    S_SORT_START = 13'b0000000000100,
    S_SORT_FIRST = 13'b0000000001000,
    S_SORT_RUN   = 13'b0000000010000,
    S_SORT_TAIL  = 13'b0000000100000,
    S_DEL_START  = 13'b0000001000000,
    S_DEL_RUN    = 13'b0000010000000,
    S_DEL_DONE   = 13'b0000100000000,
    S_RD_ISSUE   = 13'b0001000000000,
    S_RD_EMIT    = 13'b0010000000000,
    S_RESULT     = 13'b0100000000000,
    S_SPARE      = 13'b1000000000000
  } state_t;

  state_t  state, state_next;
  status_t res, res_next;
  logic    res_del, res_del_next;

  assign item_stall = state != S_IDLE;

  always_comb begin
    state_next      = state;
    res_next        = res;
    res_del_next    = res_del;
    cmd.op          = OP_NONE;
    cmd.out_load    = 1'b0;
    cmd.out_status  = ST_OK;
    cmd.use_entry   = 1'b0;
    cmd.use_removed = 1'b0;
    cmd.out_last    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.op = OP_LOAD;
          unique case (func_t'(func))
            FN_APPEND, FN_INSERT: begin
              if (stat.full) begin
                res_next     = ST_FULL;
                res_del_next = 1'b0;
                state_next   = S_RESULT;
              end else begin
                state_next = S_APPEND;
              end
            end
            FN_DELETE: begin
              if (stat.empty) begin
                res_next     = ST_NOTFOUND;
                res_del_next = 1'b1;
                state_next   = S_RESULT;
              end else begin
                state_next = S_DEL_START;
              end
            end
            FN_READ: begin
              if (stat.empty) begin
                res_next     = ST_EMPTY;
                res_del_next = 1'b0;
                state_next   = S_RESULT;
              end else begin
                state_next = S_RD_ISSUE;
              end
            end
          endcase
        end
      end
      S_APPEND: begin
        cmd.op = OP_APPEND;
        if (stat.insert && !stat.empty) begin
          state_next = S_SORT_START;
        end else begin
          res_next     = ST_OK;
          res_del_next = 1'b0;
          state_next   = S_RESULT;
        end
      end
      S_SORT_START: begin
        cmd.op     = OP_SORT_START;
        state_next = S_SORT_FIRST;
      end
      S_SORT_FIRST: begin
        cmd.op     = OP_SORT_FIRST;
        state_next = S_SORT_RUN;
      end
      S_SORT_RUN: begin
        cmd.op = OP_SORT_STEP;
        if (stat.run_last) begin
          state_next = S_SORT_TAIL;
        end
      end
      S_SORT_TAIL: begin
        cmd.op = OP_SORT_TAIL;
        if (stat.swapped) begin
          state_next = S_SORT_START;
        end else begin
          res_next     = ST_OK;
          res_del_next = 1'b0;
          state_next   = S_RESULT;
        end
      end
      S_DEL_START: begin
        cmd.op     = OP_DEL_START;
        state_next = S_DEL_RUN;
      end
      S_DEL_RUN: begin
        cmd.op = OP_DEL_STEP;
        if (stat.del_last) begin
          state_next = S_DEL_DONE;
        end
      end
      S_DEL_DONE: begin
        cmd.op       = OP_DEL_DONE;
        res_next     = stat.del_none ? ST_NOTFOUND : ST_OK;
        res_del_next = 1'b1;
        state_next   = S_RESULT;
      end
      S_RD_ISSUE: begin
        cmd.op     = OP_RD_ISSUE;
        state_next = S_RD_EMIT;
      end
      S_RD_EMIT: begin
        if (stat.out_free) begin
          cmd.op         = OP_RD_NEXT;
          cmd.out_load   = 1'b1;
          cmd.out_status = ST_ENTRY;
          cmd.use_entry  = 1'b1;
          cmd.out_last   = stat.rd_last;
          state_next     = stat.rd_last ? S_IDLE : S_RD_ISSUE;
        end
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load    = 1'b1;
          cmd.out_status  = res;
          cmd.use_removed = res_del;
          cmd.out_last    = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    res     <= res_next;
    res_del <= res_del_next;
  end

  `ASSERT_IMPL(a_load_free, cmd.out_load, stat.out_free, "result loaded over a held result")
  `ASSERT_NEXT(a_accept_busy, (state == S_IDLE) && item_valid, state != S_IDLE, "accept did not start work")

endmodule

// ----- test/tb_sorted_table_insert_delete.sv -----
// Self-checking testbench for sorted_table_insert_delete: append, insert, delete and read-out
// transactions are checked against an in-bench model of the table, under random idling.
// Depends on sti_pkg and the sorted_table_insert_delete RTL.
module tb_sorted_table_insert_delete;
  timeunit 1ns;
  timeprecision 1ps;

  import sti_pkg::*;

  localparam int DEPTH       = 32;
  localparam int PHASE_ITEMS = 82;
  localparam int HOLD_CYCLES = 400;
  localparam int STUCK_LIMIT = 12000;
  localparam int TAIL_CYCLES = 100;
  localparam int MAX_REPORTS = 10;

  class table_scoreboard;
    typedef struct packed {
      status_t     st;
      logic [31:0] ent;
      logic [5:0]  cnt;
      logic [5:0]  rem;
      logic        lst;
    } answer_t;

    logic signed [31:0] rows [DEPTH];
    int                 fill;
    answer_t            answers [$];
    int                 mismatches;

    function void clear();
      fill = 0;
      mismatches = 0;
      answers.delete();
    endfunction

    function void push(status_t st, logic [31:0] ent, int rem, bit lst);
      answer_t a;
      a.st  = st;
      a.ent = ent;
      a.cnt = 6'(fill);
      a.rem = 6'(rem);
      a.lst = lst;
      answers.push_back(a);
    endfunction

    function void note_item(func_t f, logic signed [31:0] v);
      int hits;
      int w;
      logic signed [31:0] t;
      case (f)
        FN_APPEND, FN_INSERT: begin
          if (fill >= DEPTH) begin
            push(ST_FULL, 0, 0, 1'b1);
          end else begin
            rows[fill] = v;
            fill++;
            if (f == FN_INSERT) begin
              for (int i = 0; i + 1 < fill; i++) begin
                for (int j = 0; j + 1 < fill - i; j++) begin
                  if (rows[j] > rows[j + 1]) begin
                    t = rows[j];
                    rows[j] = rows[j + 1];
                    rows[j + 1] = t;
                  end
                end
              end
            end
            push(ST_OK, 0, 0, 1'b1);
          end
        end
        FN_DELETE: begin
          hits = 0;
          w = 0;
          for (int i = 0; i < fill; i++) begin
            if (rows[i] == v) begin
              hits++;
            end else begin
              rows[w] = rows[i];
              w++;
            end
          end
          fill = w;
          push(hits != 0 ? ST_OK : ST_NOTFOUND, 0, hits, 1'b1);
        end
        default: begin
          if (fill == 0) begin
            push(ST_EMPTY, 0, 0, 1'b1);
          end else begin
            for (int i = 0; i < fill; i++) begin
              push(ST_ENTRY, rows[i], 0, i == fill - 1);
            end
          end
        end
      endcase
    endfunction

    function void check_result(logic [2:0] st, logic [31:0] ent, logic [5:0] cnt,
                               logic [5:0] rem, logic lst);
      answer_t want;
      if (answers.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result status=%0d entry=%0d count=%0d removed=%0d last=%0b",
                   $realtime, st, $signed(ent), cnt, rem, lst);
        return;
      end
      want = answers.pop_front();
      if (want.st !== st || want.ent !== ent || want.cnt !== cnt || want.rem !== rem ||
          want.lst !== lst) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: mismatch exp status=%0d entry=%0d count=%0d removed=%0d last=%0b, got status=%0d entry=%0d count=%0d removed=%0d last=%0b",
                   $realtime, want.st, $signed(want.ent), want.cnt, want.rem, want.lst,
                   st, $signed(ent), cnt, rem, lst);
      end
    endfunction

    function logic signed [31:0] pick_entry();
      if (fill == 0) return $urandom;
      return rows[$urandom_range(0, fill - 1)];
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               item_valid;
  logic               item_stall;
  logic [1:0]         func;
  logic signed [31:0] value;
  logic               result_valid;
  logic               result_stall;
  logic [2:0]         status;
  logic signed [31:0] entry;
  logic [5:0]         entry_count;
  logic [5:0]         removed;
  logic               last;

  table_scoreboard sb;
  int              send_idle_pct;
  int              recv_idle_pct;
  bit              hold_req;
  int              stuck;

  sorted_table_insert_delete #(.DEPTH(DEPTH)) uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .func(func),
    .value(value),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .status(status),
    .entry(entry),
    .entry_count(entry_count),
    .removed(removed),
    .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2, 3, 4: return $signed($urandom_range(0, 4)) - 2;
      default: return $urandom;
    endcase
  endfunction

  // offer one transaction; return at the edge where it is accepted
  task automatic offer(input func_t f, input logic signed [31:0] v);
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    func       <= f;
    value      <= v;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_item(f, v);
  endtask

  task automatic fill_burst(inout int sent);
    while (sb.fill < DEPTH) begin
      offer(func_t'($urandom_range(0, 1)), rand_value());
      sent++;
    end
    repeat (2) begin
      offer(func_t'($urandom_range(0, 1)), rand_value());
      sent++;
    end
    offer(FN_READ, $urandom);
    sent++;
  endtask

  task automatic drain(inout int sent);
    while (sb.fill > 0) begin
      if ($urandom_range(0, 7) == 0) offer(FN_DELETE, $urandom);
      else offer(FN_DELETE, sb.pick_entry());
      sent++;
    end
    offer(FN_DELETE, rand_value());
    offer(FN_READ, $urandom);
    sent += 2;
  endtask

  task automatic mixed(inout int sent);
    repeat (20) begin
      case ($urandom_range(0, 9))
        0, 1, 2: offer(FN_APPEND, rand_value());
        3, 4, 5: offer(FN_INSERT, rand_value());
        6: offer(FN_DELETE, rand_value());
        7, 8: offer(FN_DELETE, sb.pick_entry());
        default: offer(FN_READ, $urandom);
      endcase
      sent++;
    end
  endtask

  task automatic run_random(input int n);
    int sent;
    sent = 0;
    fill_burst(sent);
    while (sent < n) begin
      case ($urandom_range(0, 2))
        0: fill_burst(sent);
        1: drain(sent);
        default: mixed(sent);
      endcase
    end
  endtask

  task automatic run_directed();
    offer(FN_READ, 32'sh0);
    offer(FN_DELETE, 32'sh0);
    offer(FN_APPEND, 32'sh7FFF_FFFF);
    offer(FN_APPEND, 32'sh8000_0000);
    offer(FN_APPEND, 32'sh0);
    offer(FN_APPEND, -32'sh1);
    offer(FN_READ, 32'shFFFF_FFFF);
    offer(FN_INSERT, 32'sh1);
    offer(FN_READ, 32'sh0);
    offer(FN_DELETE, 32'sh5);
    offer(FN_APPEND, -32'sh1);
    offer(FN_INSERT, -32'sh1);
    offer(FN_DELETE, -32'sh1);
    offer(FN_READ, 32'sh0);
    offer(FN_DELETE, 32'sh8000_0000);
    offer(FN_DELETE, 32'sh7FFF_FFFF);
    offer(FN_DELETE, 32'sh0);
    offer(FN_DELETE, 32'sh1);
    offer(FN_READ, 32'sh0);
    offer(FN_INSERT, 32'sh7FFF_FFFF);
    offer(FN_INSERT, 32'sh8000_0000);
    offer(FN_READ, 32'sh0);
  endtask

  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        result_stall <= (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      sb.check_result(status, entry, entry_count, removed, last);
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      stuck <= 0;
    end else if (stuck >= STUCK_LIMIT) begin
      $display("tb_sorted_table_insert_delete: errors");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  initial begin
    sb = new();
    sb.clear();
    stuck         = 0;
    hold_req      = 1'b0;
    send_idle_pct = 30;
    recv_idle_pct = 83;
    item_valid    = 1'b0;
    func          = FN_APPEND;
    value         = '0;
    rst           = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();
    run_random(PHASE_ITEMS);
    send_idle_pct = 83;
    recv_idle_pct = 30;
    run_random(PHASE_ITEMS);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 1'b1;
    run_random(PHASE_ITEMS);
    @(negedge clk);
    item_valid <= 1'b0;

    while (sb.answers.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("tb_sorted_table_insert_delete: clean");
    end else begin
      $display("tb_sorted_table_insert_delete: errors");
    end
    $finish;
  end
endmodule
